[hdl/sad3_pkg.sv]
// Shared constants and types for the 3x3 shift SAD block.
package sad3_pkg;

  localparam int unsigned MaxWidth   = 2048;
  localparam int unsigned MaxHeight  = 2048;
  localparam int unsigned ColW       = $clog2(MaxWidth);
  localparam int unsigned RowW       = $clog2(MaxHeight);
  localparam int unsigned PixW       = 8;
  localparam int unsigned LineW      = 2 * PixW;
  localparam int unsigned SizeW      = 12;
  localparam int unsigned SumW       = 30;
  localparam int unsigned NumOffsets = 9;
  localparam int unsigned OffW       = 4;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 12;

  localparam logic [SizeW-1:0] FrameSizeReset = 12'd2048;
  localparam logic [SizeW-1:0] MinSize        = 12'd3;
  localparam logic [SumW-1:0]  SumLimit       = '1;
  localparam logic [OffW-1:0]  LastOffset     = OffW'(NumOffsets - 1);

  typedef enum logic [CfgIdxW-1:0] {
    CfgFrameWidth  = 2'd0,
    CfgFrameHeight = 2'd1,
    CfgMaskEnable  = 2'd2,
    CfgMaskIndex   = 2'd3
  } cfg_idx_e;

  typedef logic [SumW-1:0] sum_arr_t [NumOffsets];

  typedef struct packed {
    logic fire;
    logic first;
    logic interior;
    logic last;
  } step_ctl_t;

endpackage

[hdl/sad3_line_store.sv]
// Line stores: two background rows and one delayed row of current and mask.
module sad3_line_store
  import sad3_pkg::*;
(
  input  logic             clk_i,
  input  logic             rd_en_i,
  input  logic [ColW-1:0]  rd_addr_i,
  input  logic             wr_en_i,
  input  logic [ColW-1:0]  wr_addr_i,
  input  logic [LineW-1:0] bg_wdata_i,
  input  logic [LineW-1:0] ctr_wdata_i,
  output logic [LineW-1:0] bg_rdata_o,
  output logic [LineW-1:0] ctr_rdata_o
);

  logic [LineW-1:0] bg_mem  [MaxWidth];
  logic [LineW-1:0] ctr_mem [MaxWidth];
  logic [LineW-1:0] bg_rdata_q;
  logic [LineW-1:0] ctr_rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      bg_mem[wr_addr_i]  <= bg_wdata_i;
      ctr_mem[wr_addr_i] <= ctr_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      bg_rdata_q  <= bg_mem[rd_addr_i];
      ctr_rdata_q <= ctr_mem[rd_addr_i];
    end
  end

  assign bg_rdata_o  = bg_rdata_q;
  assign ctr_rdata_o = ctr_rdata_q;

endmodule

[hdl/sad3_accum.sv]
// Background window, center hold and the nine saturating difference sums.
module sad3_accum
  import sad3_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  step_ctl_t        ctl_i,
  input  logic [LineW-1:0] lines_i,
  input  logic [PixW-1:0]  bg_i,
  input  logic [LineW-1:0] delayed_i,
  input  logic             mask_en_i,
  input  logic [PixW-1:0]  mask_idx_i,
  output sum_arr_t         sums_o
);

  logic [PixW-1:0]  win_q [NumOffsets];
  logic [PixW-1:0]  win_d [NumOffsets];
  logic [LineW-1:0] hold_q;
  sum_arr_t         sums_q;
  sum_arr_t         sums_d;
  logic             count;
  logic [PixW-1:0]  cval;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_d[3*r]     = win_q[3*r+1];
      win_d[3*r + 1] = win_q[3*r+2];
    end
    win_d[2] = lines_i[LineW-1:PixW];
    win_d[5] = lines_i[PixW-1:0];
    win_d[8] = bg_i;
  end

  assign cval  = hold_q[PixW-1:0];
  assign count = ctl_i.interior && (!mask_en_i || (hold_q[LineW-1:PixW] == mask_idx_i));

  always_comb begin
    logic [SumW-1:0] base;
    logic [PixW-1:0] ad;
    logic [SumW:0]   s;
    for (int k = 0; k < NumOffsets; k++) begin
      base = ctl_i.first ? '0 : sums_q[k];
      ad   = (cval > win_d[k]) ? (cval - win_d[k]) : (win_d[k] - cval);
      s    = {1'b0, base} + {{(SumW + 1 - PixW){1'b0}}, ad};
      if (!count) begin
        sums_d[k] = base;
      end else if (s[SumW]) begin
        sums_d[k] = SumLimit;
      end else begin
        sums_d[k] = s[SumW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= '0;
      for (int k = 0; k < NumOffsets; k++) begin
        win_q[k]  <= '0;
        sums_q[k] <= '0;
      end
    end else if (ctl_i.fire) begin
      hold_q <= delayed_i;
      for (int k = 0; k < NumOffsets; k++) begin
        win_q[k]  <= win_d[k];
        sums_q[k] <= sums_d[k];
      end
    end
  end

  assign sums_o = sums_d;

  a_first_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.fire && ctl_i.first && !count) |=> (sums_q[0] == '0 && sums_q[8] == '0))
    else $error("sums not cleared at frame start");
  a_no_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.fire && !ctl_i.first && !count) |=> $stable(sums_q[4]))
    else $error("sum changed on a pixel that does not count");
  a_window_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.fire |=> (win_q[6] == $past(win_q[7]) && win_q[8] == $past(bg_i)))
    else $error("window did not shift");

endmodule

[hdl/sad3_out_buf.sv]
// Snapshot of the nine frame sums, sent one word at a time.
module sad3_out_buf
  import sad3_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  sum_arr_t        sums_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [OffW-1:0] offset_index_o,
  output logic [SumW-1:0] sum_value_o,
  output logic            last_sum_o
);

  sum_arr_t        snap_q;
  logic [OffW-1:0] idx_q;
  logic            busy_q;
  logic            take;

  assign take = busy_q && out_ready_i;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      for (int k = 0; k < NumOffsets; k++) begin
        snap_q[k] <= sums_i[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (load_i) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
    end else if (take) begin
      if (idx_q == LastOffset) begin
        busy_q <= 1'b0;
        idx_q  <= '0;
      end else begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  assign out_valid_o    = busy_q;
  assign offset_index_o = idx_q;
  assign sum_value_o    = snap_q[idx_q];
  assign last_sum_o     = (idx_q == LastOffset);

  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> !busy_q)
    else $error("snapshot loaded while words still pending");
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (idx_q <= LastOffset))
    else $error("offset index out of range");
  a_drain_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && idx_q == LastOffset && !load_i) |=> !busy_q)
    else $error("buffer still busy after last word");

endmodule

[hdl/sad_3x3_shift_sums.sv]
// Top level: config registers, raster counters, input stage and line stores.
// The first sum word is valid once the last pixel has left the input stage and the sums are loaded.
// Throughput: one pixel per cycle unless a frame end waits; nine sum words leave per frame, one per handshake.
// A frame end waits while the previous frame's nine words are still pending.
// Reset clears counters, window and sums and sets config to defaults; line stores are not cleared.
module sad_3x3_shift_sums
  import sad3_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [PixW-1:0]     current_pixel_i,
  input  logic [PixW-1:0]     background_pixel_i,
  input  logic [PixW-1:0]     mask_pixel_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [OffW-1:0]     offset_index_o,
  output logic [SumW-1:0]     sum_value_o,
  output logic                last_sum_o
);

  logic [SizeW-1:0] width_q;
  logic [SizeW-1:0] height_q;
  logic             mask_en_q;
  logic [PixW-1:0]  mask_idx_q;

  logic [ColW-1:0]  col_q;
  logic [RowW-1:0]  row_q;
  logic [ColW-1:0]  col_last;
  logic [RowW-1:0]  row_last;
  logic             at_col_end;
  logic             at_row_end;

  logic             a_valid_q;
  logic [PixW-1:0]  a_cur_q;
  logic [PixW-1:0]  a_bg_q;
  logic [PixW-1:0]  a_msk_q;
  logic [ColW-1:0]  a_col_q;
  logic             a_first_q;
  logic             a_int_q;
  logic             a_last_q;

  logic             in_take;
  logic             a_fire;
  step_ctl_t        ctl;
  logic [LineW-1:0] bg_rdata;
  logic [LineW-1:0] ctr_rdata;
  sum_arr_t         sums_next;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= FrameSizeReset;
      height_q   <= FrameSizeReset;
      mask_en_q  <= 1'b0;
      mask_idx_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgFrameWidth:  width_q    <= cfg_data_i[SizeW-1:0];
        CfgFrameHeight: height_q   <= cfg_data_i[SizeW-1:0];
        CfgMaskEnable:  mask_en_q  <= cfg_data_i[0];
        CfgMaskIndex:   mask_idx_q <= cfg_data_i[PixW-1:0];
        default: ;
      endcase
    end
  end

  assign col_last = (width_q < MinSize) ? ColW'(2) :
                    (32'(width_q) > 32'(MaxWidth)) ? ColW'(MaxWidth - 1) :
                    ColW'(width_q - 1'b1);
  assign row_last = (height_q < MinSize) ? RowW'(2) :
                    (32'(height_q) > 32'(MaxHeight)) ? RowW'(MaxHeight - 1) :
                    RowW'(height_q - 1'b1);
  assign at_col_end = (col_q >= col_last);
  assign at_row_end = (row_q >= row_last);

  assign a_fire     = a_valid_q && (!a_last_q || !out_valid_o);
  assign in_ready_o = !a_valid_q || a_fire;
  assign in_take    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      a_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        a_valid_q <= 1'b1;
        if (at_col_end) begin
          col_q <= '0;
          row_q <= at_row_end ? '0 : row_q + 1'b1;
        end else begin
          col_q <= col_q + 1'b1;
        end
      end else if (a_fire) begin
        a_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      a_cur_q   <= current_pixel_i;
      a_bg_q    <= background_pixel_i;
      a_msk_q   <= mask_pixel_i;
      a_col_q   <= col_q;
      a_first_q <= (col_q == '0) && (row_q == '0);
      a_int_q   <= (row_q >= RowW'(2)) && (col_q >= ColW'(2));
      a_last_q  <= at_col_end && at_row_end;
    end
  end

  assign ctl = '{fire: a_fire, first: a_first_q, interior: a_int_q, last: a_last_q};

  sad3_line_store u_line_store (
    .clk_i       (clk_i),
    .rd_en_i     (in_take),
    .rd_addr_i   (col_q),
    .wr_en_i     (a_fire),
    .wr_addr_i   (a_col_q),
    .bg_wdata_i  ({bg_rdata[PixW-1:0], a_bg_q}),
    .ctr_wdata_i ({a_msk_q, a_cur_q}),
    .bg_rdata_o  (bg_rdata),
    .ctr_rdata_o (ctr_rdata)
  );

  sad3_accum u_accum (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .lines_i    (bg_rdata),
    .bg_i       (a_bg_q),
    .delayed_i  (ctr_rdata),
    .mask_en_i  (mask_en_q),
    .mask_idx_i (mask_idx_q),
    .sums_o     (sums_next)
  );

  sad3_out_buf u_out_buf (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (a_fire && a_last_q),
    .sums_i         (sums_next),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .offset_index_o (offset_index_o),
    .sum_value_o    (sum_value_o),
    .last_sum_o     (last_sum_o)
  );

  a_take_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |-> (!a_valid_q || a_fire))
    else $error("word taken over a held item");
  a_frame_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_take && at_col_end && at_row_end) |=> (col_q == '0 && row_q == '0))
    else $error("counters did not wrap at frame end");
  a_end_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_fire && a_last_q) |=> (out_valid_o && offset_index_o == '0))
    else $error("frame end did not start the sum words");

endmodule
